@@ rtl/joystick_cursor_autorepeat_unit_assert.svh @@
// Assertion macros for the cursor controller.
`ifndef JOYSTICK_CURSOR_AUTOREPEAT_UNIT_ASSERT_SVH
`define JOYSTICK_CURSOR_AUTOREPEAT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JCA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cursor controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define JCA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cursor controller check failed");

`endif

@@ rtl/jca_pkg.sv @@
`default_nettype none

package jca_pkg;

	typedef struct packed {
		logic dir_up;
		logic dir_down;
		logic dir_left;
		logic dir_right;
		logic push_req;
		logic sw_one;
		logic sw_two;
	} in_word_t;

	typedef struct packed {
		logic [7:0] cur_x;
		logic [7:0] cur_y;
		logic [1:0] moves;
		logic       recentered;
	} out_word_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_DOWN,
		DIR_LEFT,
		DIR_RIGHT
	} dir_t;

	typedef struct packed {
		logic       en;
		dir_t       dir;
		logic [3:0] step;
	} move_req_t;

	typedef enum logic [2:0] {
		REG_REPEAT_DELAY,
		REG_REPEAT_PERIOD,
		REG_STEP_NORMAL,
		REG_STEP_FAST,
		REG_LIMIT_X,
		REG_LIMIT_Y,
		REG_HOME_X,
		REG_HOME_Y
	} reg_idx_t;

	localparam logic [7:0] RST_REPEAT_DELAY  = 8'd10;
	localparam logic [7:0] RST_REPEAT_PERIOD = 8'd3;
	localparam logic [3:0] RST_STEP_NORMAL   = 4'd2;
	localparam logic [3:0] RST_STEP_FAST     = 4'd4;
	localparam logic [7:0] RST_LIMIT_X       = 8'd124;
	localparam logic [7:0] RST_LIMIT_Y       = 8'd116;
	localparam logic [7:0] RST_HOME_X        = 8'd62;
	localparam logic [7:0] RST_HOME_Y        = 8'd58;

	// Lowest set line wins: up, then down, then left, then right.
	function automatic dir_t pick_dir(input logic [3:0] lines);
		dir_t d;
		if (lines[0]) begin
			d = DIR_UP;
		end else if (lines[1]) begin
			d = DIR_DOWN;
		end else if (lines[2]) begin
			d = DIR_LEFT;
		end else begin
			d = DIR_RIGHT;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/jca_move.sv @@
`default_nettype none

module jca_move #(
	parameter int COORD_BITS = 8
) (
	input  wire logic [COORD_BITS-1:0] pos_x,
	input  wire logic [COORD_BITS-1:0] pos_y,
	input  wire jca_pkg::move_req_t    req,
	input  wire logic [7:0]            limit_x,
	input  wire logic [7:0]            limit_y,
	output logic      [COORD_BITS-1:0] new_x,
	output logic      [COORD_BITS-1:0] new_y
);

	localparam int W = ((COORD_BITS > 8) ? COORD_BITS : 8) + 2;

	logic signed [W-1:0] x_w, y_w, s_w, lx_w, ly_w;

	// Both coordinates are clamped on every move, not only the one that moved.
	always_comb begin
		x_w  = W'(pos_x);
		y_w  = W'(pos_y);
		s_w  = W'(req.step);
		lx_w = W'(limit_x);
		ly_w = W'(limit_y);
		case (req.dir)
			jca_pkg::DIR_UP:   y_w = y_w - s_w;
			jca_pkg::DIR_DOWN: y_w = y_w + s_w;
			jca_pkg::DIR_LEFT: x_w = x_w - s_w;
			default:           x_w = x_w + s_w;
		endcase
		if (x_w[W-1]) begin
			x_w = '0;
		end else if (x_w > lx_w) begin
			x_w = lx_w;
		end
		if (y_w[W-1]) begin
			y_w = '0;
		end else if (y_w > ly_w) begin
			y_w = ly_w;
		end
		new_x = req.en ? COORD_BITS'(x_w) : pos_x;
		new_y = req.en ? COORD_BITS'(y_w) : pos_y;
	end

endmodule

`default_nettype wire

@@ rtl/joystick_cursor_autorepeat_unit.sv @@
// Joystick cursor controller with typematic auto-repeat.
// Input channel: one word per poll tick (in_valid, in_stall, in_word) with the
// four joystick directions, the centre push and the two buttons.
// Output channel: one word per tick (out_valid, out_stall, out_word) with the
// cursor position after the tick, the number of moves made and a recenter flag.
// Configuration: APB-style write and read of eight registers at byte address 4*i.
// A word accepted by the input register (valid_s1, word_s1) is processed there and
// its result goes into the output register (out_valid_s2, out_word_s2) once the
// output can take it. One word per cycle is taken while in_stall is low; both
// moves of a tick are computed combinationally between the two registers.
// When the receiver stalls, the output word holds and the input register keeps
// its word, so in_stall rises only while both registers are full.
// Reset clears both pipeline stages, the hold and period counters, the previous
// joystick lines and fast mode, loads the register defaults and sends the cursor
// home.
`default_nettype none

module joystick_cursor_autorepeat_unit #(
	parameter int COORD_BITS = 8,
	parameter int COUNT_BITS = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire jca_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire                     out_stall,
	output jca_pkg::out_word_t      out_word,
	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

`include "joystick_cursor_autorepeat_unit_assert.svh"

	localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [7:0] repeat_delay_q, repeat_period_q, limit_x_q, limit_y_q, home_x_q, home_y_q;
	logic [3:0] step_normal_q, step_fast_q;

	logic                  valid_s1;
	jca_pkg::in_word_t     word_s1;
	logic                  out_valid_s2;
	jca_pkg::out_word_t    out_word_s2;

	logic [4:0]            prev_joy_q;
	logic [COUNT_BITS-1:0] hold_q, period_q;
	logic                  fast_q;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;

	logic                  adv;
	logic [4:0]            joy;
	logic [3:0]            edge_lines;
	logic                  fast_n, recenter;
	jca_pkg::move_req_t    req_edge, req_rep;
	logic [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;
	logic [COUNT_BITS-1:0] hold_inc, hold_n, period_inc, period_n;
	logic                  timer_run, fire, rep_move;
	jca_pkg::out_word_t    res;
	jca_pkg::reg_idx_t     widx;
	logic                  wr_en;

	// Configuration port.
	assign pready = 1'b1;
	assign widx   = jca_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q  <= jca_pkg::RST_REPEAT_DELAY;
			repeat_period_q <= jca_pkg::RST_REPEAT_PERIOD;
			step_normal_q   <= jca_pkg::RST_STEP_NORMAL;
			step_fast_q     <= jca_pkg::RST_STEP_FAST;
			limit_x_q       <= jca_pkg::RST_LIMIT_X;
			limit_y_q       <= jca_pkg::RST_LIMIT_Y;
			home_x_q        <= jca_pkg::RST_HOME_X;
			home_y_q        <= jca_pkg::RST_HOME_Y;
		end else if (wr_en) begin
			case (widx)
				jca_pkg::REG_REPEAT_DELAY:  repeat_delay_q  <= pwdata[7:0];
				jca_pkg::REG_REPEAT_PERIOD: repeat_period_q <= pwdata[7:0];
				jca_pkg::REG_STEP_NORMAL:   step_normal_q   <= pwdata[3:0];
				jca_pkg::REG_STEP_FAST:     step_fast_q     <= pwdata[3:0];
				jca_pkg::REG_LIMIT_X:       limit_x_q       <= pwdata[7:0];
				jca_pkg::REG_LIMIT_Y:       limit_y_q       <= pwdata[7:0];
				jca_pkg::REG_HOME_X:        home_x_q        <= pwdata[7:0];
				jca_pkg::REG_HOME_Y:        home_y_q        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			jca_pkg::REG_REPEAT_DELAY:  prdata = {24'd0, repeat_delay_q};
			jca_pkg::REG_REPEAT_PERIOD: prdata = {24'd0, repeat_period_q};
			jca_pkg::REG_STEP_NORMAL:   prdata = {28'd0, step_normal_q};
			jca_pkg::REG_STEP_FAST:     prdata = {28'd0, step_fast_q};
			jca_pkg::REG_LIMIT_X:       prdata = {24'd0, limit_x_q};
			jca_pkg::REG_LIMIT_Y:       prdata = {24'd0, limit_y_q};
			jca_pkg::REG_HOME_X:        prdata = {24'd0, home_x_q};
			jca_pkg::REG_HOME_Y:        prdata = {24'd0, home_y_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// Handshake between the two stages.
	assign in_stall  = valid_s1 & out_valid_s2 & out_stall;
	assign adv       = valid_s1 & ~(out_valid_s2 & out_stall);
	assign out_valid = out_valid_s2;
	assign out_word  = out_word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// Tick processing.
	assign joy = {word_s1.push_req, word_s1.dir_right, word_s1.dir_left,
		word_s1.dir_down, word_s1.dir_up};
	assign edge_lines = joy[3:0] & ~prev_joy_q[3:0];
	assign fast_n     = word_s1.sw_one & ~word_s1.sw_two;
	assign recenter   = word_s1.sw_two & ~word_s1.sw_one;

	always_comb begin
		req_edge.en   = |edge_lines;
		req_edge.dir  = jca_pkg::pick_dir(edge_lines);
		req_edge.step = fast_q ? step_fast_q : step_normal_q;
	end

	jca_move #(.COORD_BITS(COORD_BITS)) u_move_edge (
		.pos_x(pos_x_q), .pos_y(pos_y_q), .req(req_edge),
		.limit_x(limit_x_q), .limit_y(limit_y_q), .new_x(x1), .new_y(y1)
	);

	assign x2 = recenter ? COORD_BITS'(home_x_q) : x1;
	assign y2 = recenter ? COORD_BITS'(home_y_q) : y1;

	always_comb begin
		hold_inc   = (hold_q == COUNT_MAX) ? hold_q : hold_q + 1'b1;
		timer_run  = 1'b0;
		fire       = 1'b0;
		rep_move   = 1'b0;
		hold_n     = (joy != 5'd0) ? hold_inc : '0;
		period_inc = (period_q == COUNT_MAX) ? period_q : period_q + 1'b1;
		period_n   = period_q;
		if (CW'(hold_n) >= CW'(repeat_delay_q)) begin
			timer_run = 1'b1;
			period_n  = period_inc;
			if (CW'(period_inc) >= CW'(repeat_period_q)) begin
				fire     = 1'b1;
				period_n = '0;
				if (|joy[3:0]) begin
					rep_move = 1'b1;
				end else begin
					hold_n = '0;
				end
			end
		end
		req_rep.en   = rep_move;
		req_rep.dir  = jca_pkg::pick_dir(joy[3:0]);
		req_rep.step = fast_n ? step_fast_q : step_normal_q;
	end

	jca_move #(.COORD_BITS(COORD_BITS)) u_move_rep (
		.pos_x(x2), .pos_y(y2), .req(req_rep),
		.limit_x(limit_x_q), .limit_y(limit_y_q), .new_x(x3), .new_y(y3)
	);

	always_comb begin
		res.cur_x      = 8'(x3);
		res.cur_y      = 8'(y3);
		res.moves      = {1'b0, req_edge.en} + {1'b0, rep_move};
		res.recentered = recenter;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_joy_q <= '0;
			hold_q     <= '0;
			period_q   <= '0;
			fast_q     <= 1'b0;
			pos_x_q    <= COORD_BITS'(jca_pkg::RST_HOME_X);
			pos_y_q    <= COORD_BITS'(jca_pkg::RST_HOME_Y);
		end else if (adv) begin
			prev_joy_q <= joy;
			hold_q     <= hold_n;
			period_q   <= period_n;
			fast_q     <= fast_n;
			pos_x_q    <= x3;
			pos_y_q    <= y3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_s2 <= res;
		end
	end

	`JCA_ASSERT_SAME(a_stall_needs_word, in_stall, valid_s1 && out_valid_s2)
	`JCA_ASSERT_SAME(a_fire_needs_timer, fire, timer_run)
	`JCA_ASSERT_NEXT(a_release_clears_hold, adv && (joy == 5'd0), hold_q == '0)
	`JCA_ASSERT_NEXT(a_fire_clears_period, adv && fire, period_q == '0)

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	jca_pkg::in_word_t   in_word = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	jca_pkg::out_word_t  out_word;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [4:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	joystick_cursor_autorepeat_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the register file.
	logic [7:0] delay_r, period_r, lim_x_r, lim_y_r, home_x_r, home_y_r;
	logic [3:0] step_n_r, step_f_r;

	// Shadow of the controller state.
	logic [4:0] prev_lines;
	logic [7:0] hold_ticks, period_ticks;
	logic       fast_step;
	logic [7:0] cursor_x, cursor_y;

	jca_pkg::out_word_t  cursor_due[$];
	jca_pkg::out_word_t  want_word;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int failures = 0;
	int words_sent = 0;
	int words_checked = 0;
	int recenter_seen = 0;
	int double_moves = 0;
	int n_settings = 0;
	int drain_wait;

	function automatic logic lowest_line(input logic [3:0] lines, output jca_pkg::dir_t d);
		casez (lines)
			4'b???1: d = jca_pkg::DIR_UP;
			4'b??10: d = jca_pkg::DIR_DOWN;
			4'b?100: d = jca_pkg::DIR_LEFT;
			default: d = jca_pkg::DIR_RIGHT;
		endcase
		return |lines;
	endfunction

	function automatic void step_cursor(jca_pkg::dir_t d, logic [3:0] step);
		int x, y, s, lx, ly;
		x = cursor_x;
		y = cursor_y;
		s = step;
		lx = lim_x_r;
		ly = lim_y_r;
		case (d)
			jca_pkg::DIR_UP:    y = y - s;
			jca_pkg::DIR_DOWN:  y = y + s;
			jca_pkg::DIR_LEFT:  x = x - s;
			default:            x = x + s;
		endcase
		if (x < 0) x = 0;
		else if (x > lx) x = lx;
		if (y < 0) y = 0;
		else if (y > ly) y = ly;
		cursor_x = x[7:0];
		cursor_y = y[7:0];
	endfunction

	function automatic jca_pkg::out_word_t advance_cursor(jca_pkg::in_word_t w);
		logic [4:0]          lines;
		logic [3:0]          rising;
		jca_pkg::dir_t       d;
		logic [1:0]          move_count;
		logic                homed;
		jca_pkg::out_word_t  r;
		lines = {w.push_req, w.dir_right, w.dir_left, w.dir_down, w.dir_up};
		rising = lines[3:0] & ~prev_lines[3:0];
		move_count = 2'd0;
		homed = 1'b0;
		// The edge move still uses the step chosen on the previous tick.
		if (lowest_line(rising, d)) begin
			step_cursor(d, fast_step ? step_f_r : step_n_r);
			move_count = move_count + 2'd1;
		end
		fast_step = w.sw_one & ~w.sw_two;
		if (w.sw_two & ~w.sw_one) begin
			cursor_x = home_x_r;
			cursor_y = home_y_r;
			homed = 1'b1;
		end
		if (lines != 5'd0) begin
			if (hold_ticks != 8'hFF) hold_ticks = hold_ticks + 8'd1;
		end else begin
			hold_ticks = 8'd0;
		end
		if (hold_ticks >= delay_r) begin
			if (period_ticks != 8'hFF) period_ticks = period_ticks + 8'd1;
			if (period_ticks >= period_r) begin
				if (lowest_line(lines[3:0], d)) begin
					step_cursor(d, fast_step ? step_f_r : step_n_r);
					move_count = move_count + 2'd1;
				end else begin
					hold_ticks = 8'd0;
				end
				period_ticks = 8'd0;
			end
		end
		prev_lines = lines;
		r.cur_x = cursor_x;
		r.cur_y = cursor_y;
		r.moves = move_count;
		r.recentered = homed;
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (cursor_due.size() == 0) begin
				$display("%0t: cursor word with nothing expected, actual x=%0d y=%0d moves=%0d",
					$time, out_word.cur_x, out_word.cur_y, out_word.moves);
				failures++;
			end else begin
				want_word = cursor_due.pop_front();
				compare_field("cur_x", want_word.cur_x, out_word.cur_x);
				compare_field("cur_y", want_word.cur_y, out_word.cur_y);
				compare_field("moves", want_word.moves, out_word.moves);
				compare_field("recentered", want_word.recentered, out_word.recentered);
				words_checked++;
				if (want_word.recentered) recenter_seen++;
				if (want_word.moves == 2'd2) double_moves++;
			end
		end
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	task automatic send_word(jca_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		cursor_due.push_back(advance_cursor(w));
		words_sent++;
	endtask

	task automatic wait_cursor_idle();
		in_valid <= 1'b0;
		while (cursor_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(jca_pkg::reg_idx_t idx, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			jca_pkg::REG_REPEAT_DELAY:  delay_r = data[7:0];
			jca_pkg::REG_REPEAT_PERIOD: period_r = data[7:0];
			jca_pkg::REG_STEP_NORMAL:   step_n_r = data[3:0];
			jca_pkg::REG_STEP_FAST:     step_f_r = data[3:0];
			jca_pkg::REG_LIMIT_X:       lim_x_r = data[7:0];
			jca_pkg::REG_LIMIT_Y:       lim_y_r = data[7:0];
			jca_pkg::REG_HOME_X:        home_x_r = data[7:0];
			jca_pkg::REG_HOME_Y:        home_y_r = data[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic pick_settings();
		logic [31:0] d;
		wait_cursor_idle();
		case ($urandom_range(9))
			0: d = 0;
			1: d = 255;
			default: d = $urandom_range(1, 8);
		endcase
		write_register(jca_pkg::REG_REPEAT_DELAY, d);
		case ($urandom_range(9))
			0: d = 255;
			1: d = 1;
			default: d = $urandom_range(2, 5);
		endcase
		write_register(jca_pkg::REG_REPEAT_PERIOD, d);
		write_register(jca_pkg::REG_STEP_NORMAL, $urandom_range(0, 255));
		write_register(jca_pkg::REG_STEP_FAST, $urandom_range(0, 255));
		case ($urandom_range(9))
			0: d = $urandom_range(0, 15);
			1: d = 255;
			default: d = $urandom_range(100, 254);
		endcase
		write_register(jca_pkg::REG_LIMIT_X, d);
		case ($urandom_range(9))
			0: d = $urandom_range(0, 15);
			1: d = 255;
			default: d = $urandom_range(100, 254);
		endcase
		write_register(jca_pkg::REG_LIMIT_Y, d);
		write_register(jca_pkg::REG_HOME_X, $urandom_range(0, 255));
		write_register(jca_pkg::REG_HOME_Y, $urandom_range(0, 255));
		n_settings++;
	endtask

	// Fields in order: up, down, left, right, push, sw_one, sw_two.
	task automatic test_edge_moves();
		send_idle_pct = 10;
		stall_pct = 10;
		send_word(7'b0000000);
		send_word(7'b1000000);
		send_word(7'b0000000);
		send_word(7'b0100000);
		send_word(7'b0010000);
		send_word(7'b0001000);
		send_word(7'b1111000);
		send_word(7'b0000100);
		send_word(7'b0000010);
		send_word(7'b1000010);
		send_word(7'b0000001);
		send_word(7'b0000011);
		send_word(7'b0100011);
		send_word(7'b0000000);
	endtask

	task automatic test_corner_settings();
		wait_cursor_idle();
		write_register(jca_pkg::REG_REPEAT_DELAY, 32'd0);
		write_register(jca_pkg::REG_REPEAT_PERIOD, 32'd0);
		write_register(jca_pkg::REG_STEP_NORMAL, 32'd15);
		write_register(jca_pkg::REG_STEP_FAST, 32'd0);
		write_register(jca_pkg::REG_LIMIT_X, 32'd0);
		write_register(jca_pkg::REG_LIMIT_Y, 32'd255);
		write_register(jca_pkg::REG_HOME_X, 32'd255);
		write_register(jca_pkg::REG_HOME_Y, 32'd0);
		n_settings++;
		send_word(7'b0000000);
		send_word(7'b0000001);
		send_word(7'b0010000);
		send_word(7'b0100010);
		send_word(7'b0000100);
		send_word(7'b1000000);
		send_word(7'b0000000);
	endtask

	task automatic test_hold_saturation();
		wait_cursor_idle();
		write_register(jca_pkg::REG_REPEAT_DELAY, 32'd255);
		write_register(jca_pkg::REG_REPEAT_PERIOD, 32'd40);
		write_register(jca_pkg::REG_STEP_NORMAL, 32'd1);
		write_register(jca_pkg::REG_LIMIT_X, 32'd255);
		write_register(jca_pkg::REG_LIMIT_Y, 32'd255);
		n_settings++;
		repeat (300) send_word(7'b0001000);
		send_word(7'b0000000);
		send_word(7'b0100000);
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_in, int count);
		int sent, run_len;
		logic [3:0] dirs;
		logic push, sw1, sw2;
		jca_pkg::in_word_t w;
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		for (int half = 0; half < 2; half++) begin
			pick_settings();
			sent = 0;
			while (sent < count / 2) begin
				if ($urandom_range(99) < 75) begin
					if ($urandom_range(9) < 7) dirs = 4'b0001 << $urandom_range(3);
					else dirs = 4'($urandom);
					push = ($urandom_range(4) == 0);
					case ($urandom_range(9))
						0, 1: {sw1, sw2} = 2'b10;
						2: {sw1, sw2} = 2'b01;
						3: {sw1, sw2} = 2'b11;
						default: {sw1, sw2} = 2'b00;
					endcase
					run_len = $urandom_range(1, 30);
					repeat (run_len) begin
						w = {dirs, push, sw1, sw2};
						if ($urandom_range(19) == 0)
							w = jca_pkg::in_word_t'(w ^ (7'b1 << $urandom_range(6)));
						send_word(w);
						sent++;
					end
					repeat ($urandom_range(0, 3)) begin
						send_word('0);
						sent++;
					end
				end else begin
					repeat ($urandom_range(1, 5)) begin
						send_word(jca_pkg::in_word_t'(7'($urandom)));
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		delay_r = jca_pkg::RST_REPEAT_DELAY;
		period_r = jca_pkg::RST_REPEAT_PERIOD;
		step_n_r = jca_pkg::RST_STEP_NORMAL;
		step_f_r = jca_pkg::RST_STEP_FAST;
		lim_x_r = jca_pkg::RST_LIMIT_X;
		lim_y_r = jca_pkg::RST_LIMIT_Y;
		home_x_r = jca_pkg::RST_HOME_X;
		home_y_r = jca_pkg::RST_HOME_Y;
		prev_lines = '0;
		hold_ticks = '0;
		period_ticks = '0;
		fast_step = 1'b0;
		cursor_x = jca_pkg::RST_HOME_X;
		cursor_y = jca_pkg::RST_HOME_Y;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_moves();
		test_corner_settings();
		test_hold_saturation();
		test_random_traffic(0, 0, 400);
		test_random_traffic(68, 0, 350);
		test_random_traffic(0, 68, 350);
		test_random_traffic(10, 10, 350);
		in_valid <= 1'b0;
		drain_wait = 0;
		while (cursor_due.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (cursor_due.size() != 0) begin
			$display("%0t: %0d cursor words never arrived", $time, cursor_due.size());
			failures++;
		end
		$display("Sent %0d joystick words under %0d register settings, idle and stall phases.",
			words_sent, n_settings);
		$display("Checked %0d cursor words: %0d recenters, %0d ticks with two moves.",
			words_checked, recenter_seen, double_moves);
		if (failures == 0) begin
			$display("joystick_cursor_autorepeat_unit verification clean");
		end else begin
			$display("joystick_cursor_autorepeat_unit verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("joystick_cursor_autorepeat_unit verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/jca_pkg.sv
rtl/jca_move.sv
rtl/joystick_cursor_autorepeat_unit.sv
verif/tb.sv
